@@ hw/rtl/cphe_pkg.sv @@
// ----------------------------------------------------------------------------
// cphe_pkg: shared types and helpers for the complex Horner evaluator
// Payload structs, register map sizes, sequencer states and the Q8.24
// saturation helper.
// ----------------------------------------------------------------------------
package cphe_pkg;

    // number formats and register map
    localparam int WORD_W       = 32;
    localparam int FRAC_BITS    = 24;
    localparam int COEF_W       = 2 * WORD_W;
    localparam int NUM_COEF     = 8;
    localparam int CFG_IDX_W    = $clog2(NUM_COEF);
    localparam int DEFAULT_MAX_DEGREE = 7;

    // full product and accumulator widths
    localparam int PROD_W = 2 * WORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ACC_W  = SUM_W - FRAC_BITS + 1;

    // one input beat
    typedef struct packed {
        logic signed [WORD_W-1:0] z_re;
        logic signed [WORD_W-1:0] z_im;
    } in_t;

    // one result beat
    typedef struct packed {
        logic signed [WORD_W-1:0] value_re;
        logic signed [WORD_W-1:0] value_im;
        logic signed [WORD_W-1:0] slope_re;
        logic signed [WORD_W-1:0] slope_im;
        logic                     overflow;
    } out_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // saturated word and its flag
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     clipped;
    } sat_t;

    // clip a wide accumulator to a signed word
    function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
        sat_t r;
        logic signed [ACC_W-1:0] max_v;
        logic signed [ACC_W-1:0] min_v;
        max_v = ACC_W'({1'b0, {(WORD_W-1){1'b1}}});
        min_v = -max_v - ACC_W'(1);
        if (v > max_v)
        begin
            r.value   = {1'b0, {(WORD_W-1){1'b1}}};
            r.clipped = 1'b1;
        end
        else if (v < min_v)
        begin
            r.value   = {1'b1, {(WORD_W-1){1'b0}}};
            r.clipped = 1'b1;
        end
        else
        begin
            r.value   = v[WORD_W-1:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/complex_polynomial_horner_eval_core.sv @@
// ----------------------------------------------------------------------------
// complex_polynomial_horner_eval_core: p(z) and p'(z) by Horner's rule
// Evaluates a complex Q8.24 polynomial and its derivative at one point per
// command, using one shared complex multiply-accumulate unit.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It then runs with busy
// high: each Horner step makes two passes through the one complex
// multiply-accumulate unit (four 32x32 multipliers, registered, then round,
// add and saturate), first the slope d = d*z + b, then the value
// b = b*z + coef_k, overlapped in the unit. In the first cycle with busy low
// again, done is high for exactly one cycle with the result beat on result;
// the receiver cannot stall it, and start may already be given in that cycle,
// so a new item can be taken while the last result is shown.
// The user must write coefficients through wr_en, wr_index and wr_data only
// while the block is idle; the block itself does not enforce this.
module complex_polynomial_horner_eval_core #(
    parameter int MAX_DEGREE = cphe_pkg::DEFAULT_MAX_DEGREE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cphe_pkg::in_t                       point,
    output logic                                done,
    output cphe_pkg::out_t                      result,
    input  logic                                wr_en,
    input  logic [cphe_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [cphe_pkg::COEF_W-1:0]         wr_data
);

    localparam int W      = cphe_pkg::WORD_W;
    localparam int LAST   = 2 * MAX_DEGREE;
    localparam int CNT_W  = $clog2(LAST + 1);
    localparam int IDX_W  = cphe_pkg::CFG_IDX_W;

    // control state
    cphe_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;

    // coefficient registers
    logic [cphe_pkg::COEF_W-1:0] coef_reg [cphe_pkg::NUM_COEF];

    // datapath registers
    logic signed [W-1:0] z_re_reg, z_im_reg, z_re_next, z_im_next;
    logic signed [W-1:0] b_re_reg, b_im_reg, b_re_next, b_im_next;
    logic signed [W-1:0] d_re_reg, d_im_reg, d_re_next, d_im_next;
    logic signed [cphe_pkg::PROD_W-1:0] prod_rr_reg, prod_ii_reg, prod_ri_reg, prod_ir_reg;
    logic signed [cphe_pkg::PROD_W-1:0] prod_rr_next, prod_ii_next, prod_ri_next, prod_ir_next;

    // shared unit signals
    logic signed [W-1:0]                op_re, op_im;
    logic signed [W-1:0]                add_re, add_im;
    logic signed [cphe_pkg::SUM_W-1:0]  sum_re, sum_im;
    logic signed [cphe_pkg::ACC_W-1:0]  acc_re, acc_im;
    cphe_pkg::sat_t                     sat_re, sat_im;
    logic [IDX_W-1:0]                   coef_idx;
    logic [cphe_pkg::COEF_W-1:0]        coef_sel;
    logic [cphe_pkg::COEF_W-1:0]        coef_top;
    logic                               accept;
    logic                               acc_en;
    logic                               slope_pass;

    assign accept = start && (state_reg == cphe_pkg::ST_IDLE);
    assign busy   = (state_reg != cphe_pkg::ST_IDLE);

    // even counts multiply the slope, odd counts the value
    assign op_re = cnt_reg[0] ? b_re_reg : d_re_reg;
    assign op_im = cnt_reg[0] ? b_im_reg : d_im_reg;

    assign prod_rr_next = op_re * z_re_reg;
    assign prod_ii_next = op_im * z_im_reg;
    assign prod_ri_next = op_re * z_im_reg;
    assign prod_ir_next = op_im * z_re_reg;

    // odd counts finish the slope pass, even counts from two the value pass
    assign slope_pass = cnt_reg[0];
    assign acc_en     = busy && (cnt_reg != '0);
    assign coef_idx   = IDX_W'(MAX_DEGREE) - IDX_W'(cnt_reg >> 1);
    assign coef_sel   = coef_reg[coef_idx];
    assign coef_top   = coef_reg[MAX_DEGREE];

    assign add_re = slope_pass ? b_re_reg : coef_sel[2*W-1:W];
    assign add_im = slope_pass ? b_im_reg : coef_sel[W-1:0];

    // sum of products, round half up, add addend, saturate
    assign sum_re = cphe_pkg::SUM_W'(prod_rr_reg) - cphe_pkg::SUM_W'(prod_ii_reg)
                  + cphe_pkg::SUM_W'(1 << (cphe_pkg::FRAC_BITS - 1));
    assign sum_im = cphe_pkg::SUM_W'(prod_ri_reg) + cphe_pkg::SUM_W'(prod_ir_reg)
                  + cphe_pkg::SUM_W'(1 << (cphe_pkg::FRAC_BITS - 1));
    assign acc_re = cphe_pkg::ACC_W'(sum_re >>> cphe_pkg::FRAC_BITS)
                  + cphe_pkg::ACC_W'(add_re);
    assign acc_im = cphe_pkg::ACC_W'(sum_im >>> cphe_pkg::FRAC_BITS)
                  + cphe_pkg::ACC_W'(add_im);
    assign sat_re = cphe_pkg::sat_word(acc_re);
    assign sat_im = cphe_pkg::sat_word(acc_im);

    // sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        z_re_next  = z_re_reg;
        z_im_next  = z_im_reg;
        b_re_next  = b_re_reg;
        b_im_next  = b_im_reg;
        d_re_next  = d_re_reg;
        d_im_next  = d_im_reg;
        case (state_reg)
            cphe_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cphe_pkg::ST_RUN;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    z_re_next  = point.z_re;
                    z_im_next  = point.z_im;
                    b_re_next  = coef_top[2*W-1:W];
                    b_im_next  = coef_top[W-1:0];
                    d_re_next  = '0;
                    d_im_next  = '0;
                end
            end
            cphe_pkg::ST_RUN:
            begin
                if (acc_en)
                begin
                    ovf_next = ovf_reg | sat_re.clipped | sat_im.clipped;
                    if (slope_pass)
                    begin
                        d_re_next = sat_re.value;
                        d_im_next = sat_im.value;
                    end
                    else
                    begin
                        b_re_next = sat_re.value;
                        b_im_next = sat_im.value;
                    end
                end
                if (cnt_reg == CNT_W'(LAST))
                begin
                    state_next = cphe_pkg::ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = cphe_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cphe_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
        end
    end

    // coefficient writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cphe_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            coef_reg[wr_index] <= wr_data;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        z_re_reg    <= z_re_next;
        z_im_reg    <= z_im_next;
        b_re_reg    <= b_re_next;
        b_im_reg    <= b_im_next;
        d_re_reg    <= d_re_next;
        d_im_reg    <= d_im_next;
        prod_rr_reg <= prod_rr_next;
        prod_ii_reg <= prod_ii_next;
        prod_ri_reg <= prod_ri_next;
        prod_ir_reg <= prod_ir_next;
    end

    // result beat
    assign done            = done_reg;
    assign result.value_re = b_re_reg;
    assign result.value_im = b_im_reg;
    assign result.slope_re = d_re_reg;
    assign result.slope_im = d_im_reg;
    assign result.overflow = ovf_reg;

    // a result beat only follows a finished run
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done without a finished run");

    // an accepted command starts a run
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && cnt_reg == '0))
        else $error("accepted command did not start a run");

    // the step counter never passes the last pass
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (cnt_reg <= CNT_W'(LAST)))
        else $error("step counter out of range");

    // the run ends exactly at the last pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy && cnt_reg == CNT_W'(LAST)) |=> (done && !busy))
        else $error("run did not end at the last pass");

endmodule
